// ===== rtl/mcsm_pkg.sv =====
// Shared types and constants for the multichannel sliding median core.
`timescale 1ns / 1ps

package mcsm_pkg;

    localparam int CH_W      = 5;
    localparam int LEN_W     = 5;
    localparam int SAMPLE_W  = 32;
    // wide enough for any count or position up to a window of 64
    localparam int CMP_W     = 7;
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = CH_W;
    localparam int M_TDATA_W = 32;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_DONE
    } mcsm_state_t;

endpackage

// ===== rtl/multichannel_sliding_median_core.sv =====
// Multichannel sliding median: per-channel sample rows in one RAM, rank by insertion sort.
// Words are taken one at a time: a new word is taken only once the current result word is in the output
// register, and a rejected word skips the load phase. The single RAM read port streams the channel row
// one entry per cycle into the insertion sorter.
// Reset: aresetn clears the write positions, then a clearing pass writes zero to all
// CHANNELS*MAX_WINDOW RAM entries, one per cycle, with s_tready low throughout.
`timescale 1ns / 1ps

module multichannel_sliding_median_core
    import mcsm_pkg::*;
#(
    parameter int CHANNELS   = 32,
    parameter int MAX_WINDOW = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [4:0] window_len, [36:5] sample, [39:37] zero
    input  logic [S_TUSER_W-1:0] s_tuser,  // [4:0] channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // [31:0] median
    output logic                 m_tuser   // [0] rejected
);

    localparam int DEPTH  = CHANNELS * MAX_WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(MAX_WINDOW);
    localparam int CHI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);

    mcsm_state_t state_reg, state_next;

    sample_t                mem [DEPTH];
    sample_t                rd_data_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    sample_t                mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;

    logic [POS_W-1:0]       pos_reg [CHANNELS];
    logic [ADDR_W-1:0]      clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]      row_base_reg, row_base_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   rej_reg, rej_next;
    sample_t                sort_reg [MAX_WINDOW];
    sample_t                sort_next [MAX_WINDOW];
    logic                   m_tvalid_reg, m_tvalid_next;
    sample_t                median_reg, median_next;
    logic                   rejected_reg, rejected_next;

    // input word decode
    logic [CH_W-1:0]        in_ch;
    logic [LEN_W-1:0]       in_len;
    sample_t                in_sample;
    logic                   in_accept;
    logic                   in_reject;
    logic [CHI_W-1:0]       in_chi;
    logic [POS_W-1:0]       pos_cur;
    logic [CMP_W-1:0]       pos_inc;
    logic [POS_W-1:0]       pos_new;
    logic [ADDR_W-1:0]      in_base;

    logic                   rd_issue;
    logic [MAX_WINDOW-1:0]  le;

    assign in_ch     = s_tuser[CH_W-1:0];
    assign in_len    = s_tdata[LEN_W-1:0];
    assign in_sample = $signed(s_tdata[LEN_W +: SAMPLE_W]);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_reject = (32'(in_ch) >= 32'(CHANNELS)) || (32'(in_len) >= 32'(MAX_WINDOW))
                       || (in_len == '0);
    assign in_chi    = CHI_W'(in_ch);
    assign pos_cur   = pos_reg[in_chi];
    assign pos_inc   = CMP_W'(pos_cur) + CMP_W'(1);
    assign pos_new   = (pos_inc >= CMP_W'(in_len)) ? '0 : POS_W'(pos_inc);
    assign in_base   = ADDR_W'(32'(in_ch) * 32'(MAX_WINDOW));

    assign rd_issue  = (state_reg == ST_LOAD) && (CMP_W'(rd_idx_reg) < CMP_W'(len_reg));
    assign mem_raddr = row_base_reg + ADDR_W'(rd_idx_reg);

    // sorted insert: le marks the prefix of slots holding values <= the new one
    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            le[i] = (CMP_W'(i) < CMP_W'(cnt_reg)) && !(rd_data_reg < sort_reg[i]);
        end
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (le[i]) begin
                sort_next[i] = sort_reg[i];
            end else if (i == 0) begin
                sort_next[i] = rd_data_reg;
            end else if (le[(i > 0) ? i - 1 : 0]) begin
                sort_next[i] = rd_data_reg;
            end else begin
                sort_next[i] = sort_reg[(i > 0) ? i - 1 : 0];
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        row_base_next = row_base_reg;
        len_next      = len_reg;
        rd_idx_next   = rd_idx_reg;
        rd_pend_next  = 1'b0;
        cnt_next      = cnt_reg;
        rej_next      = rej_reg;
        median_next   = median_reg;
        rejected_next = rejected_reg;
        mem_we        = 1'b0;
        mem_waddr     = clr_addr_reg;
        mem_wdata     = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (32'(clr_addr_reg) == 32'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    len_next      = in_len;
                    rej_next      = in_reject;
                    row_base_next = in_base;
                    rd_idx_next   = '0;
                    cnt_next      = '0;
                    if (in_reject) begin
                        state_next = ST_DONE;
                    end else begin
                        mem_we     = 1'b1;
                        mem_waddr  = in_base + ADDR_W'(pos_new);
                        mem_wdata  = in_sample;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                rd_pend_next = rd_issue;
                if (rd_issue) begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (rd_pend_reg) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (!rd_issue && !rd_pend_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    rejected_next = rej_reg;
                    median_next   = rej_reg ? '0 : sort_reg[POS_W'(len_reg >> 1)];
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            rd_pend_reg  <= 1'b0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                pos_reg[c] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            rd_pend_reg  <= rd_pend_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (in_accept && !in_reject) begin
                pos_reg[in_chi] <= pos_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        row_base_reg <= row_base_next;
        len_reg      <= len_next;
        rd_idx_reg   <= rd_idx_next;
        rej_reg      <= rej_next;
        median_reg   <= median_next;
        rejected_reg <= rejected_next;
        if (state_reg == ST_LOAD && rd_pend_reg) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                sort_reg[i] <= sort_next[i];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'($unsigned(median_reg));
    assign m_tuser  = rejected_reg;

`ifndef NO_ASSERTIONS
    // the sorter never holds more entries than the window
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> (CMP_W'(cnt_reg) <= CMP_W'(len_reg)))
        else $error("sorter count exceeds window length");

    // leaving the load phase, every window entry has been ranked
    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD && state_next == ST_DONE)
            |-> (CMP_W'(cnt_reg) == CMP_W'(len_reg)))
        else $error("median taken before window fully loaded");

    // a stored write position always lies inside the window that wrote it
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && !in_reject) |-> (CMP_W'(pos_new) < CMP_W'(in_len)))
        else $error("write position outside window");

    // a pending result is never overwritten
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_tvalid_reg && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result dropped while output stalled");

    // no input word is taken during the clearing pass
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input accepted during clear");
`endif

endmodule
